### rtl/tctp_pkg.sv
// Shared types, constants, node addressing and the control program of the placement unit.
`default_nettype none
package tctp_pkg;

    localparam int TREE_HEIGHT = 3;
    localparam int LEAF_W      = 7;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int LEVEL_W     = 2;
    localparam int POS_W       = TREE_HEIGHT;
    localparam int TREE_W      = LEAF_W - POS_W;
    localparam int NODE_W      = TREE_HEIGHT + 1;
    localparam int ADDR_W      = TREE_W + NODE_W;
    localparam int DEPTH       = 1 << ADDR_W;
    localparam int PC_W        = 3;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [PC_W-1:0]    t_pc;

    localparam logic [STATUS_W-1:0] ST_FIRST    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SECOND   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PATH     = 2'd3;

    localparam logic [1:0] COND_NEVER = 2'd0;
    localparam logic [1:0] COND_CLIMB = 2'd1;
    localparam logic [1:0] COND_MORE  = 2'd2;

    localparam t_pc PC_INIT   = 3'd0;
    localparam t_pc PC_CLIMB  = 3'd1;
    localparam t_pc PC_PLACE  = 3'd2;
    localparam t_pc PC_ISSUE  = 3'd3;
    localparam t_pc PC_EMIT   = 3'd4;

    localparam t_level TOP_LEVEL = LEVEL_W'(TREE_HEIGHT);

    typedef struct packed {
        logic       init;
        logic       climb;
        logic       place;
        logic       rd_issue;
        logic       rd_emit;
        logic [1:0] cond;
        t_pc        target;
        logic       fin;
    } t_uword;

    typedef struct packed {
        logic climb_busy;
        logic more_levels;
    } t_dp_stat;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '0;
        case (pc)
            PC_INIT: begin
                w.init = 1'b1;
            end
            PC_CLIMB: begin
                w.climb  = 1'b1;
                w.cond   = COND_CLIMB;
                w.target = PC_CLIMB;
            end
            PC_PLACE: begin
                w.place = 1'b1;
                w.fin   = 1'b1;
            end
            PC_ISSUE: begin
                w.rd_issue = 1'b1;
            end
            PC_EMIT: begin
                w.rd_emit = 1'b1;
                w.cond    = COND_MORE;
                w.target  = PC_ISSUE;
                w.fin     = 1'b1;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

    // Heap numbering inside a tree: the node on the path to a leaf at a given depth.
    function automatic t_addr node_addr(input logic [LEAF_W-1:0] leaf, input t_level lvl);
        logic [NODE_W-1:0] first;
        logic [NODE_W-1:0] offs;
        logic [POS_W-1:0]  pos;
        pos   = leaf[POS_W-1:0];
        first = (NODE_W'(1) << lvl) - NODE_W'(1);
        offs  = NODE_W'(pos >> (LEVEL_W'(TREE_HEIGHT) - lvl));
        return {leaf[LEAF_W-1:POS_W], first + offs};
    endfunction

endpackage
`default_nettype wire

### rtl/tctp_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module tctp_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire                  i_action,
    input  tctp_pkg::t_dp_stat   i_stat,
    output tctp_pkg::t_uword     o_uword,
    output logic                 o_busy
);

    logic             r_run;
    logic             n_run;
    tctp_pkg::t_pc    r_pc;
    tctp_pkg::t_pc    n_pc;
    tctp_pkg::t_uword uw;
    logic             take;

    always_comb begin
        uw = r_run ? tctp_pkg::ucode(r_pc) : '0;
        case (uw.cond)
            tctp_pkg::COND_CLIMB: take = i_stat.climb_busy;
            tctp_pkg::COND_MORE:  take = i_stat.more_levels;
            default:              take = 1'b0;
        endcase
        n_run = r_run;
        n_pc  = r_pc;
        if (!r_run) begin
            if (i_accept) begin
                n_run = 1'b1;
                n_pc  = i_action ? tctp_pkg::PC_ISSUE : tctp_pkg::PC_INIT;
            end
        end else if (take) begin
            n_pc = uw.target;
        end else if (uw.fin) begin
            n_run = 1'b0;
        end else begin
            n_pc = r_pc + tctp_pkg::t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= tctp_pkg::PC_INIT;
        end else begin
            r_run <= n_run;
            r_pc  <= n_pc;
        end
    end

    assign o_uword = uw;
    assign o_busy  = r_run;

endmodule
`default_nettype wire

### rtl/tctp_dp.sv
// Datapath: node store, occupancy bits, the two climbs and the result register.
`default_nettype none
module tctp_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_accept,
    input  wire [tctp_pkg::LEAF_W-1:0]       i_first_leaf,
    input  wire [tctp_pkg::LEAF_W-1:0]       i_second_leaf,
    input  wire [tctp_pkg::VALUE_W-1:0]      i_value,
    input  tctp_pkg::t_uword                 i_uword,
    output tctp_pkg::t_dp_stat               o_stat,
    output logic                             o_result_valid,
    output logic [tctp_pkg::STATUS_W-1:0]    o_status,
    output logic [tctp_pkg::LEAF_W-1:0]      o_chosen_leaf,
    output logic [tctp_pkg::LEVEL_W-1:0]     o_node_level,
    output logic [tctp_pkg::VALUE_W-1:0]     o_node_value,
    output logic                             o_node_valid,
    output logic                             o_last
);

    logic [tctp_pkg::VALUE_W-1:0] mem [tctp_pkg::DEPTH];
    logic [tctp_pkg::DEPTH-1:0]   r_used;

    logic [tctp_pkg::LEAF_W-1:0]  r_leaf0;
    logic [tctp_pkg::LEAF_W-1:0]  r_leaf1;
    logic [tctp_pkg::VALUE_W-1:0] r_value;
    tctp_pkg::t_level             r_lvl0;
    tctp_pkg::t_level             r_lvl1;
    tctp_pkg::t_level             n_lvl0;
    tctp_pkg::t_level             n_lvl1;
    logic                         r_occ0;
    logic                         r_occ1;
    logic                         r_done0;
    logic                         r_done1;
    logic                         n_done0;
    logic                         n_done1;
    tctp_pkg::t_level             r_rlvl;
    logic [tctp_pkg::VALUE_W-1:0] r_rdata;
    logic                         r_rused;

    logic                         up0;
    logic                         up1;
    logic                         pick1;
    logic                         overflow;
    tctp_pkg::t_addr              waddr;
    tctp_pkg::t_addr              raddr;

    logic                         r_ovalid;
    logic [tctp_pkg::STATUS_W-1:0] r_ostatus;
    logic [tctp_pkg::LEAF_W-1:0]  r_oleaf;
    tctp_pkg::t_level             r_olevel;
    logic [tctp_pkg::VALUE_W-1:0] r_ovalue;
    logic                         r_ovld;
    logic                         r_olast;

    always_comb begin
        up0 = (r_lvl0 != '0)
            && !r_used[tctp_pkg::node_addr(r_leaf0, r_lvl0 - tctp_pkg::t_level'(1))];
        up1 = (r_lvl1 != '0)
            && !r_used[tctp_pkg::node_addr(r_leaf1, r_lvl1 - tctp_pkg::t_level'(1))];
        n_lvl0  = (!r_done0 && up0) ? r_lvl0 - tctp_pkg::t_level'(1) : r_lvl0;
        n_lvl1  = (!r_done1 && up1) ? r_lvl1 - tctp_pkg::t_level'(1) : r_lvl1;
        n_done0 = r_done0 || !up0;
        n_done1 = r_done1 || !up1;
        overflow = r_occ0 && r_occ1;
        pick1    = r_occ0 || (!r_occ1 && (r_lvl1 < r_lvl0));
        waddr    = pick1 ? tctp_pkg::node_addr(r_leaf1, r_lvl1)
                         : tctp_pkg::node_addr(r_leaf0, r_lvl0);
        raddr    = tctp_pkg::node_addr(r_leaf0, r_rlvl);
        o_stat.climb_busy  = !(n_done0 && n_done1);
        o_stat.more_levels = (r_rlvl != tctp_pkg::TOP_LEVEL);
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.place && !overflow) begin
            mem[waddr] <= r_value;
        end
        if (i_uword.rd_issue) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_uword.place && !overflow) begin
            r_used[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_leaf0 <= i_first_leaf;
            r_leaf1 <= i_second_leaf;
            r_value <= i_value;
            r_rlvl  <= '0;
        end
        if (i_uword.init) begin
            r_lvl0  <= tctp_pkg::TOP_LEVEL;
            r_lvl1  <= tctp_pkg::TOP_LEVEL;
            r_occ0  <= r_used[tctp_pkg::node_addr(r_leaf0, tctp_pkg::TOP_LEVEL)];
            r_occ1  <= r_used[tctp_pkg::node_addr(r_leaf1, tctp_pkg::TOP_LEVEL)];
            r_done0 <= r_used[tctp_pkg::node_addr(r_leaf0, tctp_pkg::TOP_LEVEL)];
            r_done1 <= r_used[tctp_pkg::node_addr(r_leaf1, tctp_pkg::TOP_LEVEL)];
        end
        if (i_uword.climb) begin
            r_lvl0  <= n_lvl0;
            r_lvl1  <= n_lvl1;
            r_done0 <= n_done0;
            r_done1 <= n_done1;
        end
        if (i_uword.rd_issue) begin
            r_rused <= r_used[raddr];
        end
        if (i_uword.rd_emit) begin
            r_rlvl <= r_rlvl + tctp_pkg::t_level'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= i_uword.place || i_uword.rd_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.place) begin
            r_olast <= 1'b1;
            if (overflow) begin
                r_ostatus <= tctp_pkg::ST_OVERFLOW;
                r_oleaf   <= '0;
                r_olevel  <= '0;
                r_ovalue  <= '0;
                r_ovld    <= 1'b0;
            end else begin
                r_ostatus <= pick1 ? tctp_pkg::ST_SECOND : tctp_pkg::ST_FIRST;
                r_oleaf   <= pick1 ? r_leaf1 : r_leaf0;
                r_olevel  <= pick1 ? r_lvl1 : r_lvl0;
                r_ovalue  <= r_value;
                r_ovld    <= 1'b1;
            end
        end else if (i_uword.rd_emit) begin
            r_ostatus <= tctp_pkg::ST_PATH;
            r_oleaf   <= r_leaf0;
            r_olevel  <= r_rlvl;
            r_ovalue  <= r_rused ? r_rdata : '0;
            r_ovld    <= r_rused;
            r_olast   <= (r_rlvl == tctp_pkg::TOP_LEVEL);
        end
    end

    assign o_result_valid = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_chosen_leaf  = r_oleaf;
    assign o_node_level   = r_olevel;
    assign o_node_value   = r_ovalue;
    assign o_node_valid   = r_ovld;
    assign o_last         = r_olast;

endmodule
`default_nettype wire

### rtl/two_choice_tree_placement_unit.sv
// Top level of the two-choice tree placement unit.
//
//  Channel   Transfer condition          Payload
//  -------   -------------------------   -----------------------------------------------
//  input     start high and busy low     i_action, i_first_leaf, i_second_leaf, i_value
//  result    o_result_valid high         o_status, o_chosen_leaf, o_node_level,
//                                        o_node_value, o_node_valid, o_last
//
// An insert keeps busy high through a step that samples both leaves, then climb steps that
// run the two parallel climbs up to the step that sees both climbs end, and then a step
// that writes the node.
// A read alternates an issue step and an emit step for each path node, as the node store read is registered.
// Results are registered, appear in the cycle after the step that forms them and cannot be stalled.
// Synchronous reset empties every node at once; the node store itself is not cleared.
`default_nettype none
module two_choice_tree_placement_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_action,
    input  wire [tctp_pkg::LEAF_W-1:0]       i_first_leaf,
    input  wire [tctp_pkg::LEAF_W-1:0]       i_second_leaf,
    input  wire [tctp_pkg::VALUE_W-1:0]      i_value,
    output logic                             o_result_valid,
    output logic [tctp_pkg::STATUS_W-1:0]    o_status,
    output logic [tctp_pkg::LEAF_W-1:0]      o_chosen_leaf,
    output logic [tctp_pkg::LEVEL_W-1:0]     o_node_level,
    output logic [tctp_pkg::VALUE_W-1:0]     o_node_value,
    output logic                             o_node_valid,
    output logic                             o_last
);

    tctp_pkg::t_uword   uword;
    tctp_pkg::t_dp_stat stat;
    logic               seq_busy;
    logic               accept;

    assign accept = start && !seq_busy;
    assign busy   = seq_busy;

    tctp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_action),
        .i_stat   (stat),
        .o_uword  (uword),
        .o_busy   (seq_busy)
    );

    tctp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_first_leaf   (i_first_leaf),
        .i_second_leaf  (i_second_leaf),
        .i_value        (i_value),
        .i_uword        (uword),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_chosen_leaf  (o_chosen_leaf),
        .o_node_level   (o_node_level),
        .o_node_value   (o_node_value),
        .o_node_valid   (o_node_valid),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
